// ===== rtl/ppdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pairwise point distance rows: shared definitions
// Widths, codes and the result tag that travels down the distance pipeline.
// ----------------------------------------------------------------------------
package ppdr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = 6;
	localparam int N_W        = 7;
	localparam int COORD_W    = 16;
	localparam int POS_W      = 11;
	localparam int DIST_W     = 17;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int ROOT_STEPS = DIST_W;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int REM_W      = DIST_W + 1;
	localparam int NP_MIN     = 2;
	localparam int NP_CAP     = 64;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic       CMD_LOAD       = 1'b0;
	localparam logic       CMD_QUERY      = 1'b1;
	localparam logic       STATUS_OK      = 1'b0;
	localparam logic       STATUS_RANGE   = 1'b1;
	localparam logic [0:0] REG_NUM_POINTS = 1'b0;

	typedef logic [2*COORD_W-1:0] point_t;

	typedef struct packed {
		logic [IDX_W-1:0] other_index;
		logic [POS_W-1:0] table_position;
		logic             last;
		logic             err;
	} tag_t;

endpackage

// ===== rtl/pairwise_point_distance_rows.sv =====
// ----------------------------------------------------------------------------
// Pairwise point distance rows
// Stores 2-D points in a 64-entry memory and, on a query, streams the distance
// from the named point to every other point together with its pair position.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                cmd, point_index, x_coord, y_coord
// result    out        valid (one cycle, no stall)  other_index, table_position,
//                                                   distance, status, last
// config    in         APB, pready tied high        num_points at byte address 0
//
// A load is written to the point memory at the accepting edge; busy stays low.
// A query keeps busy high until its final result leaves: one memory read per
// point, one point per cycle, and each result passes through the read,
// difference, squares, sum and a 17-step square root.
// A range error keeps busy high until its single error result leaves.
// Reset clears control state only; the point memory is not cleared.
// ----------------------------------------------------------------------------
module pairwise_point_distance_rows (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cmd,
	input  logic [ppdr_pkg::IDX_W-1:0]         point_index,
	input  logic [ppdr_pkg::COORD_W-1:0]       x_coord,
	input  logic [ppdr_pkg::COORD_W-1:0]       y_coord,
	output logic                               valid,
	output logic [ppdr_pkg::IDX_W-1:0]         other_index,
	output logic [ppdr_pkg::POS_W-1:0]         table_position,
	output logic [ppdr_pkg::DIST_W-1:0]        distance,
	output logic                               status,
	output logic                               last,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ppdr_pkg::ADDR_W-1:0]        paddr,
	input  logic [ppdr_pkg::DATA_W-1:0]        pwdata,
	output logic [ppdr_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SELF  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_ERR   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	localparam int IW = ppdr_pkg::IDX_W;
	localparam int NW = ppdr_pkg::N_W;
	localparam int PW = ppdr_pkg::POS_W;
	localparam int CW = ppdr_pkg::COORD_W;
	localparam int RS = ppdr_pkg::ROOT_STEPS;
	localparam int RW = ppdr_pkg::REM_W;

	// Configuration register
	logic [NW-1:0] np_q;
	logic [NW-1:0] np_eff;
	logic          cfg_wr;

	// Sequencer
	logic [2:0]    state_q;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] j_q;
	logic [NW-1:0] j_inc;
	logic [NW-1:0] j_nx;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_nx;
	logic          run_last;
	logic          query_acc;
	logic          load_acc;
	logic          self_cap_q;
	ppdr_pkg::point_t self_q;

	// Memory
	ppdr_pkg::point_t point_mem [ppdr_pkg::MAX_POINTS];
	logic [IW-1:0]    rd_addr;
	ppdr_pkg::point_t rd_data_s1;

	// Front pipeline
	logic              iss_valid;
	ppdr_pkg::tag_t    iss_tag;
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	ppdr_pkg::tag_t    tag_s1, tag_s2, tag_s3, tag_s4;
	logic [CW-1:0]     ax, ay, bx, by;
	logic [CW-1:0]     dx_s2, dy_s2;
	logic [ppdr_pkg::SQ_W-1:0]  sqx_s3, sqy_s3;
	logic [ppdr_pkg::SUM_W-1:0] sum_s4;

	// Square root pipeline, one result bit per stage
	logic                       rt_valid_s [RS];
	ppdr_pkg::tag_t             rt_tag_s   [RS];
	logic [RW-1:0]              rt_rem_s   [RS];
	logic [RS-1:0]              rt_root_s  [RS];
	logic [ppdr_pkg::RAD_W-1:0] rt_v_s     [RS];

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ppdr_pkg::ADDR_W-1:2] == ppdr_pkg::REG_NUM_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q <= NW'(ppdr_pkg::NP_MIN);
		end else if (cfg_wr) begin
			np_q <= pwdata[NW-1:0];
		end
	end

	always_comb begin
		if (paddr[ppdr_pkg::ADDR_W-1:2] == ppdr_pkg::REG_NUM_POINTS) begin
			prdata = {(ppdr_pkg::DATA_W-NW)'(0), np_q};
		end else begin
			prdata = '0;
		end
	end

	always_comb begin
		if (np_q < NW'(ppdr_pkg::NP_MIN)) begin
			np_eff = NW'(ppdr_pkg::NP_MIN);
		end else if (np_q > NW'(ppdr_pkg::NP_CAP)) begin
			np_eff = NW'(ppdr_pkg::NP_CAP);
		end else begin
			np_eff = np_q;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign busy      = (state_q != ST_IDLE);
	assign query_acc = start && !busy && (cmd == ppdr_pkg::CMD_QUERY);
	assign load_acc  = start && !busy && (cmd == ppdr_pkg::CMD_LOAD);

	// The queried point itself is skipped when stepping to the next partner.
	always_comb begin
		j_inc    = j_q + NW'(1);
		j_nx     = (j_inc == {1'b0, idx_q}) ? j_q + NW'(2) : j_inc;
		run_last = (j_nx >= n_q);
	end

	// Rows before the queried point advance by the length of the next row;
	// crossing the queried point jumps to the start of its own row.
	always_comb begin
		if (j_inc < {1'b0, idx_q}) begin
			pos_nx = pos_q + PW'(n_q - NW'(2) - j_q);
		end else if (j_inc == {1'b0, idx_q}) begin
			pos_nx = pos_q + PW'(n_q - {1'b0, idx_q});
		end else begin
			pos_nx = pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			n_q        <= NW'(ppdr_pkg::NP_MIN);
			j_q        <= '0;
			pos_q      <= '0;
			self_cap_q <= 1'b0;
		end else begin
			self_cap_q <= (state_q == ST_SELF);
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						idx_q <= point_index;
						n_q   <= np_eff;
						if (point_index == '0) begin
							j_q   <= NW'(1);
							pos_q <= '0;
						end else begin
							j_q   <= '0;
							pos_q <= PW'(point_index) - PW'(1);
						end
						if ({1'b0, point_index} >= np_eff) begin
							state_q <= ST_ERR;
						end else begin
							state_q <= ST_SELF;
						end
					end
				end
				ST_SELF: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					j_q   <= j_nx;
					pos_q <= pos_nx;
					if (run_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_ERR: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (valid && last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The queried point is read first and held for the whole row.
	always_ff @(posedge clk) begin
		if (self_cap_q) begin
			self_q <= rd_data_s1;
		end
	end

	// ------------------------------------------------------------------
	// Point memory: one write port, one registered read port
	// ------------------------------------------------------------------
	assign rd_addr = (state_q == ST_SELF) ? idx_q : j_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (load_acc) begin
			point_mem[point_index] <= {y_coord, x_coord};
		end
		rd_data_s1 <= point_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Distance pipeline front: difference, squares, sum
	// ------------------------------------------------------------------
	always_comb begin
		iss_valid = (state_q == ST_RUN) || (state_q == ST_ERR);
		if (state_q == ST_ERR) begin
			iss_tag.other_index    = '0;
			iss_tag.table_position = '0;
			iss_tag.last           = 1'b1;
			iss_tag.err            = ppdr_pkg::STATUS_RANGE;
		end else begin
			iss_tag.other_index    = j_q[IW-1:0];
			iss_tag.table_position = pos_q;
			iss_tag.last           = run_last;
			iss_tag.err            = ppdr_pkg::STATUS_OK;
		end
	end

	assign ax = self_q[CW-1:0];
	assign ay = self_q[2*CW-1:CW];
	assign bx = rd_data_s1[CW-1:0];
	assign by = rd_data_s1[2*CW-1:CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= iss_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss_tag;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		// An error result carries a zero distance.
		if (tag_s1.err) begin
			dx_s2 <= '0;
			dy_s2 <= '0;
		end else begin
			dx_s2 <= (ax > bx) ? ax - bx : bx - ax;
			dy_s2 <= (ay > by) ? ay - by : by - ay;
		end
		sqx_s3 <= ppdr_pkg::SQ_W'(dx_s2) * ppdr_pkg::SQ_W'(dx_s2);
		sqy_s3 <= ppdr_pkg::SQ_W'(dy_s2) * ppdr_pkg::SQ_W'(dy_s2);
		sum_s4 <= ppdr_pkg::SUM_W'(sqx_s3) + ppdr_pkg::SUM_W'(sqy_s3);
	end

	// ------------------------------------------------------------------
	// Square root: each stage brings down two radicand bits and settles one
	// root bit by trial subtraction.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < RS; k++) begin : g_root
		logic                       in_valid;
		ppdr_pkg::tag_t             in_tag;
		logic [RW-1:0]              in_rem;
		logic [RS-1:0]              in_root;
		logic [ppdr_pkg::RAD_W-1:0] in_v;
		logic [RW+1:0]              r_sh;
		logic [RW+1:0]              trial;
		logic [RW+1:0]              diff;
		logic                       ge;

		if (k == 0) begin : g_first
			assign in_valid = valid_s4;
			assign in_tag   = tag_s4;
			assign in_rem   = '0;
			assign in_root  = '0;
			assign in_v     = ppdr_pkg::RAD_W'(sum_s4);
		end else begin : g_next
			assign in_valid = rt_valid_s[k-1];
			assign in_tag   = rt_tag_s[k-1];
			assign in_rem   = rt_rem_s[k-1];
			assign in_root  = rt_root_s[k-1];
			assign in_v     = rt_v_s[k-1];
		end

		assign r_sh  = {in_rem, in_v[2*(RS-1-k)+1 -: 2]};
		assign trial = (RW+2)'({in_root, 2'b01});
		assign diff  = r_sh - trial;
		assign ge    = (r_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_valid_s[k] <= 1'b0;
			end else begin
				rt_valid_s[k] <= in_valid;
			end
		end

		always_ff @(posedge clk) begin
			rt_tag_s[k]  <= in_tag;
			rt_v_s[k]    <= in_v;
			rt_root_s[k] <= {in_root[RS-2:0], ge};
			rt_rem_s[k]  <= ge ? diff[RW-1:0] : r_sh[RW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Result ports
	// ------------------------------------------------------------------
	assign valid          = rt_valid_s[RS-1];
	assign other_index    = rt_tag_s[RS-1].other_index;
	assign table_position = rt_tag_s[RS-1].table_position;
	assign distance       = rt_root_s[RS-1];
	assign status         = rt_tag_s[RS-1].err;
	assign last           = rt_tag_s[RS-1].last;

`ifndef SYNTHESIS
	// Results only appear while a query is in progress.
	a_result_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("result strobe outside a query");

	// A range error is the single, final result of its query.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status) |-> last)
		else $error("error result without last");

	// The block is free again right after the final result.
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !busy)
		else $error("busy after final result");

	// An idle block has nothing in flight behind the memory read.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !valid_s1)
		else $error("pipeline not empty while idle");

	// A row never pairs the queried point with itself.
	a_no_self_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !status) |-> (other_index != idx_q))
		else $error("queried point paired with itself");
`endif

endmodule
